>>> src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared sizes, codes, types and helpers for the text console character
// engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int FCNT_W    = $clog2(CELLS + 1);

    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int EXT_W     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam int TAB_STEP  = 8;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7F;

    localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'd1;

    localparam logic [COLOR_W-1:0] RESET_FORE = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BACK = 4'h0;

    typedef struct packed {
        logic load;
        logic put_apply;
        logic clear_start;
        logic read_issue;
        logic fill_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_read;
        logic need_scroll;
        logic fill_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   data;
    } t_cfg_wr;

    function automatic logic [CELL_W-1:0] blank_cell(
        input logic [COLOR_W-1:0] fore,
        input logic [COLOR_W-1:0] back
    );
        return {back, fore, CH_SPACE};
    endfunction

endpackage

>>> src/tcce_in_if.sv
// ----------------------------------------------------------------------------
// tcce_in_if
// Input word channel: mode, character code and read index.
// ----------------------------------------------------------------------------
interface tcce_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcce_pkg::MODE_W-1:0]  mode;
    logic [tcce_pkg::CHAR_W-1:0]  char_code;
    logic [tcce_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, mode, char_code, read_index, input ready);
    modport sink   (input valid, mode, char_code, read_index, output ready);
endinterface

>>> src/tcce_out_if.sv
// ----------------------------------------------------------------------------
// tcce_out_if
// Result word channel: cursor position, read data and scroll flag.
// ----------------------------------------------------------------------------
interface tcce_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcce_pkg::POS_W-1:0]   cursor_position;
    logic [tcce_pkg::CELL_W-1:0]  read_data;
    logic                         scrolled;

    modport source (output valid, cursor_position, read_data, scrolled, input ready);
    modport sink   (input valid, cursor_position, read_data, scrolled, output ready);
endinterface

>>> src/tcce_cfg_if.sv
// ----------------------------------------------------------------------------
// tcce_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcce_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tcce_pkg::CFG_IDX_W-1:0] index;
    logic [tcce_pkg::COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: initial clear sweep, item decode, fill sweeps, cell reads and
// result hand-off.
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcce_pkg::t_status i_status,
    output tcce_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_EXEC = 6'b000100,
        S_READ = 6'b001000,
        S_FILL = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_put) begin
                    o_cmd.put_apply = 1'b1;
                    n_state = i_status.need_scroll ? S_FILL : S_DONE;
                end else if (i_status.is_clear) begin
                    o_cmd.clear_start = 1'b1;
                    n_state = S_FILL;
                end else if (i_status.is_read) begin
                    o_cmd.read_issue = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/tcce_dp.sv
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: cell store with ring row offset, cursor, colors, fill engine and
// result register.
// ----------------------------------------------------------------------------
module tcce_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcce_pkg::MODE_W-1:0]   i_in_mode,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_in_char,
    input  logic [tcce_pkg::IDX_W-1:0]    i_in_idx,
    input  tcce_pkg::t_cfg_wr             i_cfg,
    input  tcce_pkg::t_cmd                i_cmd,
    output tcce_pkg::t_status             o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tcce_pkg::POS_W-1:0]    o_cursor_position,
    output logic [tcce_pkg::CELL_W-1:0]   o_read_data,
    output logic                          o_scrolled
);

    localparam int AW = tcce_pkg::ADDR_W;
    localparam int CW = tcce_pkg::COL_W;

    logic [tcce_pkg::CELL_W-1:0]  r_mem [tcce_pkg::CELLS];
    logic [tcce_pkg::CELL_W-1:0]  r_mem_q;

    logic [CW-1:0]                r_col;
    logic [tcce_pkg::ROW_W-1:0]   r_row;
    logic [AW-1:0]                r_row_base;
    logic [AW-1:0]                r_top_base;
    logic [tcce_pkg::COLOR_W-1:0] r_fore;
    logic [tcce_pkg::COLOR_W-1:0] r_back;
    logic [AW-1:0]                r_fill_addr;
    logic [tcce_pkg::FCNT_W-1:0]  r_fill_cnt;
    logic [tcce_pkg::CELL_W-1:0]  r_fill_cell;
    logic                         r_out_valid;

    logic [tcce_pkg::MODE_W-1:0]  r_mode;
    logic [tcce_pkg::CHAR_W-1:0]  r_char;
    logic [tcce_pkg::IDX_W-1:0]   r_ridx;
    logic                         r_scrolled;
    logic                         r_rd_ok;
    logic [tcce_pkg::POS_W-1:0]   r_out_pos;
    logic [tcce_pkg::CELL_W-1:0]  r_out_data;
    logic                         r_out_scr;

    logic [CW:0]                  n_col_x;
    logic [CW-1:0]                n_col;
    logic                         row_inc;
    logic                         printable;
    logic                         scroll;
    logic [AW:0]                  wr_sum;
    logic [AW-1:0]                wr_phys;
    logic [tcce_pkg::EXT_W-1:0]   rd_ext;
    logic [tcce_pkg::EXT_W-1:0]   rd_sum;
    logic [AW-1:0]                rd_phys;
    logic                         rd_in_range;
    logic [AW:0]                  pos_sum;
    logic [AW-1:0]                top_next;
    logic [tcce_pkg::CELL_W-1:0]  cur_blank;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tcce_pkg::CELL_W-1:0]  mem_wdata;

    assign cur_blank = tcce_pkg::blank_cell(r_fore, r_back);
    assign printable = (r_char >= tcce_pkg::CH_SPACE) && (r_char <= tcce_pkg::CH_LAST);

    always_comb begin
        n_col_x = {1'b0, r_col};
        row_inc = 1'b0;
        case (r_char)
            tcce_pkg::CH_BS: begin
                if (r_col != '0) begin
                    n_col_x = n_col_x - 1'b1;
                end
            end
            tcce_pkg::CH_TAB: begin
                n_col_x = (n_col_x + (CW+1)'(tcce_pkg::TAB_STEP))
                        & ~(CW+1)'(tcce_pkg::TAB_STEP - 1);
            end
            tcce_pkg::CH_CR: begin
                n_col_x = '0;
            end
            tcce_pkg::CH_LF: begin
                n_col_x = '0;
                row_inc = 1'b1;
            end
            default: begin
                if (printable) begin
                    n_col_x = n_col_x + 1'b1;
                end
            end
        endcase
        if (n_col_x >= (CW+1)'(tcce_pkg::COLUMNS)) begin
            n_col_x = '0;
            row_inc = 1'b1;
        end
    end

    assign n_col  = n_col_x[CW-1:0];
    assign scroll = row_inc && (r_row == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1));

    assign wr_sum  = (AW+1)'(r_row_base) + (AW+1)'(r_col) + (AW+1)'(r_top_base);
    assign wr_phys = (wr_sum >= (AW+1)'(tcce_pkg::CELLS))
                   ? AW'(wr_sum - (AW+1)'(tcce_pkg::CELLS)) : AW'(wr_sum);

    assign rd_ext      = tcce_pkg::EXT_W'(r_ridx);
    assign rd_in_range = rd_ext < tcce_pkg::EXT_W'(tcce_pkg::CELLS);
    assign rd_sum      = rd_ext + tcce_pkg::EXT_W'(r_top_base);
    assign rd_phys     = (rd_sum >= tcce_pkg::EXT_W'(tcce_pkg::CELLS))
                       ? AW'(rd_sum - tcce_pkg::EXT_W'(tcce_pkg::CELLS)) : AW'(rd_sum);

    assign pos_sum  = (AW+1)'(r_row_base) + (AW+1)'(r_col);
    assign top_next = (r_top_base == AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS))
                    ? '0 : AW'(r_top_base + AW'(tcce_pkg::COLUMNS));

    assign mem_we    = (i_cmd.put_apply && printable) || i_cmd.fill_step;
    assign mem_waddr = i_cmd.fill_step ? r_fill_addr : wr_phys;
    assign mem_wdata = i_cmd.fill_step ? r_fill_cell : {r_back, r_fore, r_char};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_issue) begin
            r_mem_q <= r_mem[rd_phys];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_base  <= '0;
            r_top_base  <= '0;
            r_fore      <= tcce_pkg::RESET_FORE;
            r_back      <= tcce_pkg::RESET_BACK;
            r_fill_addr <= '0;
            r_fill_cnt  <= tcce_pkg::FCNT_W'(tcce_pkg::CELLS);
            r_fill_cell <= tcce_pkg::blank_cell(tcce_pkg::RESET_FORE, tcce_pkg::RESET_BACK);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    tcce_pkg::REG_FORE: r_fore <= i_cfg.data;
                    tcce_pkg::REG_BACK: r_back <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.put_apply) begin
                r_col <= n_col;
                if (scroll) begin
                    r_top_base  <= top_next;
                    r_fill_addr <= r_top_base;
                    r_fill_cnt  <= tcce_pkg::FCNT_W'(tcce_pkg::COLUMNS);
                    r_fill_cell <= cur_blank;
                end else if (row_inc) begin
                    r_row      <= r_row + 1'b1;
                    r_row_base <= r_row_base + AW'(tcce_pkg::COLUMNS);
                end
            end
            if (i_cmd.clear_start) begin
                r_col       <= '0;
                r_row       <= '0;
                r_row_base  <= '0;
                r_top_base  <= '0;
                r_fill_addr <= '0;
                r_fill_cnt  <= tcce_pkg::FCNT_W'(tcce_pkg::CELLS);
                r_fill_cell <= cur_blank;
            end
            if (i_cmd.fill_step) begin
                r_fill_addr <= r_fill_addr + 1'b1;
                r_fill_cnt  <= r_fill_cnt - 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_in_mode;
            r_char     <= i_in_char;
            r_ridx     <= i_in_idx;
            r_scrolled <= 1'b0;
            r_rd_ok    <= 1'b0;
        end
        if (i_cmd.put_apply) begin
            r_scrolled <= scroll;
        end
        if (i_cmd.read_issue) begin
            r_rd_ok <= rd_in_range;
        end
        if (i_cmd.out_load) begin
            r_out_pos  <= tcce_pkg::POS_W'(pos_sum);
            r_out_data <= ((r_mode == tcce_pkg::MODE_READ) && r_rd_ok) ? r_mem_q : '0;
            r_out_scr  <= r_scrolled;
        end
    end

    assign o_status.is_put      = (r_mode == tcce_pkg::MODE_PUT);
    assign o_status.is_clear    = (r_mode == tcce_pkg::MODE_CLEAR);
    assign o_status.is_read     = (r_mode == tcce_pkg::MODE_READ);
    assign o_status.need_scroll = scroll;
    assign o_status.fill_last   = (r_fill_cnt == tcce_pkg::FCNT_W'(1));
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_read_data       = r_out_data;
    assign o_scrolled        = r_out_scr;

    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> (r_fill_cnt != '0))
        else $error("fill step with empty count");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < CW'(tcce_pkg::COLUMNS)) && (r_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS)))
        else $error("cursor out of range");

    a_row_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.clear_start) |-> (r_row_base == '0) && (r_top_base == '0))
        else $error("clear did not home cursor and ring");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top_base <= AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS))
        else $error("ring offset out of range");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result not presented after load");

endmodule

>>> src/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text console over a COLUMNS x ROWS store of character/attribute words.
//
// Channels: i_in takes one word per item (mode, char_code, read_index);
// o_out returns exactly one word per item (cursor_position, read_data,
// scrolled); i_cfg writes fore_color (index 0) and back_color (index 1) and
// is always ready.
// From accept to result valid: put without scroll and the unused mode
// pass through the EXEC and DONE states, a read also through READ, and a
// put that scrolls or a clear also through a FILL sweep of COLUMNS or
// COLUMNS*ROWS cells. The fill engine writes one cell per cycle through
// the single write port, so that sweep sets the item time. One item is in
// work at a time; i_in.ready rises in the same cycle as the result, so a
// new word is taken only after the previous result has been loaded.
// Reset: the cursor homes, colors return to white on black, and a clearing
// sweep of all COLUMNS*ROWS (2000) cells blanks the store with i_in.ready low.
// Stall: the result sits in an output register; the next word is accepted
// while it waits, and its own result is held back until o_out is taken.
// ----------------------------------------------------------------------------
module text_console_character_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcce_in_if.sink     i_in,
    tcce_out_if.source  o_out,
    tcce_cfg_if.sink    i_cfg
);

    tcce_pkg::t_cmd    cmd;
    tcce_pkg::t_status status;
    tcce_pkg::t_cfg_wr cfg_wr;
    logic              in_ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr.we   = i_cfg.valid;
    assign cfg_wr.idx  = i_cfg.index;
    assign cfg_wr.data = i_cfg.data;
    assign i_in.ready  = in_ready;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcce_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_mode         (i_in.mode),
        .i_in_char         (i_in.char_code),
        .i_in_idx          (i_in.read_index),
        .i_cfg             (cfg_wr),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_cursor_position (o_out.cursor_position),
        .o_read_data       (o_out.read_data),
        .o_scrolled        (o_out.scrolled)
    );

endmodule
